FILE: sv/wocnt_pkg.sv
// Shared types and constants for the window occupancy counter.
// Used by wocnt_ctrl, wocnt_datapath and window_occupancy_count.
`default_nettype none

package wocnt_pkg;

  localparam int FUNC_W   = 2;
  localparam int POS_W    = 6;
  localparam int CFG_W    = 7;
  localparam int RADCFG_W = 3;
  localparam int IDX_W    = 2;
  localparam int CNT_W    = 8;

  localparam logic [FUNC_W-1:0] FUNC_SET  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLR  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CNT  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_RADIUS = 2'd2;

  localparam logic [CFG_W-1:0]    SIDE_RST   = 7'd64;
  localparam logic [RADCFG_W-1:0] RADIUS_RST = 3'd0;
  localparam logic [CNT_W-1:0]    CNT_MAX    = '1;

  typedef struct packed {
    logic load;
    logic cnt_rd;
    logic wr_rd;
    logic wr_wb;
    logic out_load;
    logic out_bad;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_grid;
    logic last_row;
  } ctl_sts_t;

endpackage

`default_nettype wire

FILE: sv/wocnt_ctrl.sv
// Sequencer for the window occupancy counter: item decode, row sweep, drain.
// Depends on wocnt_pkg for command/status structs and function codes.
`default_nettype none

module wocnt_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [wocnt_pkg::FUNC_W-1:0]   in_func,
  input  wire wocnt_pkg::ctl_sts_t            sts,
  output wocnt_pkg::ctl_cmd_t                 cmd,
  output logic                                busy,
  output logic                                out_valid
);
  import wocnt_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_WR_RD  = 3'd1;
  localparam logic [2:0] ST_WR_WB  = 3'd2;
  localparam logic [2:0] ST_CNT_RD = 3'd3;
  localparam logic [2:0] ST_DRAIN1 = 3'd4;
  localparam logic [2:0] ST_DRAIN2 = 3'd5;
  localparam logic [2:0] ST_FIN    = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          unique case (in_func)
            FUNC_NONE: ;
            FUNC_CNT: begin
              if (!sts.in_grid) begin
                cmd.out_load = 1'b1;
                cmd.out_bad  = 1'b1;
              end else begin
                state_nxt = ST_CNT_RD;
              end
            end
            FUNC_SET, FUNC_CLR: begin
              if (!sts.in_grid) begin
                cmd.out_load = 1'b1;
                cmd.out_bad  = 1'b1;
              end else begin
                state_nxt = ST_WR_RD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WR_RD: begin
        cmd.wr_rd = 1'b1;
        state_nxt = ST_WR_WB;
      end
      ST_WR_WB: begin
        cmd.wr_wb = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_CNT_RD: begin
        cmd.cnt_rd = 1'b1;
        if (sts.last_row) begin
          state_nxt = ST_DRAIN1;
        end
      end
      ST_DRAIN1: state_nxt = ST_DRAIN2;
      ST_DRAIN2: state_nxt = ST_FIN;
      ST_FIN: begin
        cmd.out_load = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.out_load;
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/wocnt_datapath.sv
// Datapath: config registers, occupancy row memory, window mask, popcount and sum.
// Depends on wocnt_pkg; driven by commands from wocnt_ctrl.
`default_nettype none

module wocnt_datapath #(
  parameter int MAX_SIDE   = 64,
  parameter int MAX_RADIUS = 7
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [wocnt_pkg::IDX_W-1:0]       cfg_index,
  input  wire logic [wocnt_pkg::CFG_W-1:0]       cfg_wdata,
  input  wire logic [wocnt_pkg::FUNC_W-1:0]      in_func,
  input  wire logic [wocnt_pkg::POS_W-1:0]       in_pos_x,
  input  wire logic [wocnt_pkg::POS_W-1:0]       in_pos_y,
  input  wire wocnt_pkg::ctl_cmd_t               cmd,
  output wocnt_pkg::ctl_sts_t                    sts,
  output logic [wocnt_pkg::CNT_W-1:0]            out_count,
  output logic                                   out_bad_position
);
  import wocnt_pkg::*;

  localparam int AW   = $clog2(MAX_SIDE);
  localparam int SW   = $clog2(MAX_SIDE + 1);
  localparam int RW   = $clog2(MAX_RADIUS + 1);
  localparam int CW   = ((SW > POS_W) ? SW : POS_W) + 1;
  localparam int NCH  = (MAX_SIDE + 7) / 8;
  localparam int PADW = NCH * 8;
  localparam int CHW  = 4;
  localparam int PCW  = $clog2(PADW + 1);
  localparam int SUMW = ((PCW > CNT_W) ? PCW : CNT_W) + 1;

  logic [CFG_W-1:0]    width_r, height_r;
  logic [RADCFG_W-1:0] radius_r;
  logic [SW-1:0]       w_eff, h_eff;
  logic [RW-1:0]       r_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIDE_RST;
      height_r <= SIDE_RST;
      radius_r <= RADIUS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_wdata;
        REG_HEIGHT: height_r <= cfg_wdata;
        REG_RADIUS: radius_r <= cfg_wdata[RADCFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (width_r == '0) w_eff = SW'(1);
    else if (int'(width_r) > MAX_SIDE) w_eff = SW'(MAX_SIDE);
    else w_eff = SW'(width_r);
    priority if (height_r == '0) h_eff = SW'(1);
    else if (int'(height_r) > MAX_SIDE) h_eff = SW'(MAX_SIDE);
    else h_eff = SW'(height_r);
    if (int'(radius_r) > MAX_RADIUS) r_eff = RW'(MAX_RADIUS);
    else r_eff = RW'(radius_r);
  end

  // window bounds from the incoming item
  logic [CW-1:0]       cx, cy, cr, cw, ch;
  logic [CW-1:0]       xlo, xhi, xsum, ylo, yhi, ysum;
  logic [MAX_SIDE-1:0] mask_nxt;

  assign cx   = CW'(in_pos_x);
  assign cy   = CW'(in_pos_y);
  assign cr   = CW'(r_eff);
  assign cw   = CW'(w_eff);
  assign ch   = CW'(h_eff);
  assign xsum = cx + cr;
  assign ysum = cy + cr;
  assign xlo  = (cx >= cr) ? (cx - cr) : '0;
  assign ylo  = (cy >= cr) ? (cy - cr) : '0;
  assign xhi  = (xsum >= cw) ? (cw - CW'(1)) : xsum;
  assign yhi  = (ysum >= ch) ? (ch - CW'(1)) : ysum;

  assign sts.in_grid = (cx < cw) && (cy < ch);

  always_comb begin
    for (int i = 0; i < MAX_SIDE; i++) begin
      mask_nxt[i] = (CW'(i) >= xlo) && (CW'(i) <= xhi);
    end
  end

  logic [AW-1:0]       x_r;
  logic [CW-1:0]       y_r, row_r, yhi_r;
  logic [MAX_SIDE-1:0] mask_r;
  logic                set_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r    <= AW'(in_pos_x);
      y_r    <= cy;
      row_r  <= ylo;
      yhi_r  <= yhi;
      mask_r <= mask_nxt;
      set_r  <= (in_func == FUNC_SET);
    end else if (cmd.cnt_rd) begin
      row_r <= row_r + CW'(1);
    end
  end

  assign sts.last_row = (row_r == yhi_r);

  // row memory with per-row valid bits cleared at reset
  logic [MAX_SIDE-1:0] mem [MAX_SIDE];
  logic [MAX_SIDE-1:0] row_vld_r;
  logic [MAX_SIDE-1:0] rdata_r, row_eff, cen_bit, wdata, masked;
  logic [AW-1:0]       rd_addr;
  logic                rvld1_r, cen1_r, v1_r, v2_r;

  assign rd_addr = cmd.wr_rd ? y_r[AW-1:0] : row_r[AW-1:0];
  assign row_eff = rvld1_r ? rdata_r : '0;
  assign cen_bit = {{(MAX_SIDE-1){1'b0}}, 1'b1} << x_r;
  assign wdata   = set_r ? (row_eff | cen_bit) : (row_eff & ~cen_bit);

  always_ff @(posedge clk) begin
    if (cmd.cnt_rd || cmd.wr_rd) begin
      rdata_r <= mem[rd_addr];
    end
    if (cmd.wr_wb) begin
      mem[y_r[AW-1:0]] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
    end else begin
      if (cmd.wr_wb) begin
        row_vld_r[y_r[AW-1:0]] <= 1'b1;
      end
      v1_r <= cmd.cnt_rd;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cnt_rd || cmd.wr_rd) begin
      rvld1_r <= row_vld_r[rd_addr];
      cen1_r  <= (row_r == y_r);
    end
  end

  // per-byte popcount, registered
  logic [PADW-1:0] padded;
  logic [CHW-1:0]  chunk_nxt [NCH];
  logic [CHW-1:0]  chunk_r   [NCH];

  assign masked = row_eff & mask_r & ~(cen1_r ? cen_bit : '0);
  assign padded = PADW'(masked);

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      chunk_nxt[c] = '0;
      for (int b = 0; b < 8; b++) begin
        chunk_nxt[c] = chunk_nxt[c] + CHW'(padded[c*8 + b]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NCH; c++) begin
      chunk_r[c] <= chunk_nxt[c];
    end
  end

  // row sum into saturating accumulator
  logic [PCW-1:0]   pc;
  logic [SUMW-1:0]  total;
  logic [CNT_W-1:0] acc_r, acc_nxt;

  always_comb begin
    pc = '0;
    for (int c = 0; c < NCH; c++) begin
      pc = pc + PCW'(chunk_r[c]);
    end
  end

  assign total   = SUMW'(acc_r) + SUMW'(pc);
  assign acc_nxt = (total > SUMW'(CNT_MAX)) ? CNT_MAX : CNT_W'(total);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_nxt;
    end
  end

  logic [CNT_W-1:0] out_count_r;
  logic             out_bad_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_count_r <= cmd.out_bad ? '0 : acc_r;
      out_bad_r   <= cmd.out_bad;
    end
  end

  assign out_count        = out_count_r;
  assign out_bad_position = out_bad_r;

endmodule

`default_nettype wire

FILE: sv/window_occupancy_count.sv
// Window occupancy counter top level: one-bit occupancy map with windowed counts.
// Joins wocnt_ctrl and wocnt_datapath; depends on wocnt_pkg.
//
// Usage:
//   Input: an item is taken when start is high and busy is low. in_func selects
//   set cell, clear cell or count window at (in_pos_x, in_pos_y).
//   Output: out_valid marks one cycle holding out_count and out_bad_position;
//   the receiver cannot stall, so the result must be taken in that cycle.
//   Config: cfg_we writes cfg_wdata to the register at cfg_index (0 width,
//   1 height, 2 radius) at the clock edge; write only while busy is low.
//   Timing: count inside the grid sweeps the n window rows inside the grid
//   (at most 2*radius+1): the row memory gives one row per cycle, then two
//   pipeline stages (masked byte popcount, row sum) and the result register.
//   The result shows in the cycle busy falls. Set or clear inside the grid
//   does a row read, modify and write back and gives no result. An item
//   outside the grid leaves busy low and its flagged result shows in the
//   next cycle; func code 3 is dropped.
//   Reset (rst_n low, synchronous) clears all row valid bits, so the map reads
//   empty at once, and restores the registers to 64, 64 and 0.
`default_nettype none

module window_occupancy_count #(
  parameter int MAX_SIDE   = 64,
  parameter int MAX_RADIUS = 7
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [wocnt_pkg::FUNC_W-1:0]    in_func,
  input  wire logic [wocnt_pkg::POS_W-1:0]     in_pos_x,
  input  wire logic [wocnt_pkg::POS_W-1:0]     in_pos_y,
  output logic                                 out_valid,
  output logic [wocnt_pkg::CNT_W-1:0]          out_count,
  output logic                                 out_bad_position,
  input  wire logic                            cfg_we,
  input  wire logic [wocnt_pkg::IDX_W-1:0]     cfg_index,
  input  wire logic [wocnt_pkg::CFG_W-1:0]     cfg_wdata
);
  import wocnt_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  wocnt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_func   (in_func),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  wocnt_datapath #(
    .MAX_SIDE   (MAX_SIDE),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_func          (in_func),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .cmd              (cmd),
    .sts              (sts),
    .out_count        (out_count),
    .out_bad_position (out_bad_position)
  );

  a_out_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while an item is still in work");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_position) |-> (out_count == '0))
    else $error("flagged result carries a nonzero count");

  a_drop_none: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == FUNC_NONE) |=> (!out_valid && !busy))
    else $error("unused function code produced work or a result");

  a_cnt_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == FUNC_CNT) |=> (busy || out_valid))
    else $error("count item neither started nor answered");

endmodule

`default_nettype wire
